/* rtl/core/iira_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed insert/remove array package
// Shared widths, opcodes, status codes and the cell control struct.
// ----------------------------------------------------------------------------
package iira_pkg;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 6;
   localparam int OPCODE_W    = 3;
   localparam int STATUS_W    = 2;
   localparam int FILL_W      = 7;
   localparam int CAPACITY_DF = 64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_READ   = 3'd4,
      OP_WRITE  = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic ins;
      logic rem;
      logic app;
      logic wr;
   } cell_ctl_type;

endpackage

/* rtl/core/indexed_insert_remove_array_top.sv */
// ----------------------------------------------------------------------------
// Indexed insert/remove array
// An ordered store of signed words in a row of cells with a fill count.
//
//   Channel   Ports                                        Direction
//   req       req_valid/ready, opcode, position, word_in   in
//   rsp       rsp_valid/ready, word_out, status, fill_count out
//
// For every request all cells shift, load or hold in parallel, and the response
// appears in the output register on the next cycle.
// A new request is taken each cycle while the output register is empty or
// being drained, so the sustained rate is one request per cycle.
// Reset clears the fill count and the response valid flag; entry contents and
// response fields are not cleared. A stalled response holds the request channel off.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array_top #(
   parameter int CAPACITY = iira_pkg::CAPACITY_DF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [iira_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [iira_pkg::POS_W-1:0]           req_position,
   input  logic signed [iira_pkg::WORD_W-1:0]   req_word_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [iira_pkg::WORD_W-1:0]   rsp_word_out,
   output logic [iira_pkg::STATUS_W-1:0]        rsp_status,
   output logic [iira_pkg::FILL_W-1:0]          rsp_fill_count
);
   import iira_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   status_type               status_ff;
   status_type               status_in;
   logic [FILL_W-1:0]        fill_ff;

   logic                     accept;
   logic [CMP_W-1:0]         pos_ext;
   logic [CMP_W-1:0]         count_ext;
   logic [CMP_W-1:0]         sel;
   logic                     in_range;
   logic                     full;
   logic                     take_word;
   cell_ctl_type             ctl;
   logic signed [WORD_W-1:0] gather;

   logic signed [WORD_W-1:0] data_w [CAPACITY];
   logic signed [WORD_W-1:0] tap_w  [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pos_ext   = CMP_W'(req_position);
   assign count_ext = CMP_W'(count_ff);
   assign in_range  = pos_ext < count_ext;
   assign full      = count_ff == CAP_CNT;

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      ctl       = '0;
      sel       = pos_ext;
      take_word = 1'b0;
      unique case (op_type'(req_opcode))
         OP_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctl.app  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP: begin
            sel = count_ext - 1'b1;
            if (count_ff == '0) begin
               status_in = ST_RANGE;
            end else begin
               take_word = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         OP_INSERT: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               ctl.ins  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else begin
               ctl.rem   = 1'b1;
               take_word = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else begin
               take_word = 1'b1;
            end
         end
         OP_WRITE: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else begin
               ctl.wr = 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      if (!accept) begin
         ctl      = '0;
         count_in = count_ff;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [WORD_W-1:0] left_w;
         logic signed [WORD_W-1:0] right_w;
         if (gi == 0) begin : g_first
            assign left_w = req_word_in;
         end else begin : g_mid_left
            assign left_w = data_w[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_w = data_w[gi];
         end else begin : g_mid_right
            assign right_w = data_w[gi+1];
         end
         iira_cell #(
            .INDEX (gi),
            .CMP_W (CMP_W)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .pos        (pos_ext),
            .count      (count_ext),
            .sel        (sel),
            .word       (req_word_in),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (data_w[gi]),
            .tap        (tap_w[gi])
         );
      end
   endgenerate

   always_comb begin
      gather = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         gather = gather | tap_w[i];
      end
   end

   assign word_in = take_word ? gather : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff   <= word_in;
         status_ff <= status_in;
         fill_ff   <= FILL_W'(count_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_out   = word_ff;
   assign rsp_status     = status_ff;
   assign rsp_fill_count = fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("fill count exceeds capacity");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_APPEND) && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("append did not grow the fill count");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != ST_OK)) |-> (word_ff == '0))
      else $error("refused request returned a nonzero word");

   a_fill_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(reset)) |-> (fill_ff == FILL_W'(count_ff)))
      else $error("response fill count differs from the stored count");

endmodule

/* rtl/core/iira_cell.sv */
// ----------------------------------------------------------------------------
// Indexed insert/remove array cell
// Holds one entry and takes its next value from itself, its lower neighbor,
// its upper neighbor or the request word, according to the broadcast command.
// ----------------------------------------------------------------------------
module iira_cell #(
   parameter int INDEX = 0,
   parameter int CMP_W = 7
) (
   input  logic                              clock,
   input  iira_pkg::cell_ctl_type            ctl,
   input  logic [CMP_W-1:0]                  pos,
   input  logic [CMP_W-1:0]                  count,
   input  logic [CMP_W-1:0]                  sel,
   input  logic signed [iira_pkg::WORD_W-1:0] word,
   input  logic signed [iira_pkg::WORD_W-1:0] left_data,
   input  logic signed [iira_pkg::WORD_W-1:0] right_data,
   output logic signed [iira_pkg::WORD_W-1:0] data,
   output logic signed [iira_pkg::WORD_W-1:0] tap
);
   import iira_pkg::*;

   localparam logic [CMP_W-1:0] IDX  = CMP_W'(INDEX);
   localparam logic [CMP_W-1:0] IDX1 = CMP_W'(INDEX + 1);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (IDX == pos) begin
            data_in = word;
         end else if ((IDX > pos) && (IDX <= count)) begin
            data_in = left_data;
         end
      end
      if (ctl.rem && (IDX >= pos) && (IDX1 < count)) begin
         data_in = right_data;
      end
      if (ctl.app && (IDX == count)) begin
         data_in = word;
      end
      if (ctl.wr && (IDX == pos)) begin
         data_in = word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = (IDX == sel) ? data_ff : '0;

endmodule

/* verif/tb_indexed_insert_remove_array_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed insert/remove array testbench
// Drives a table of directed requests and then a long random run that swings
// the fill count between empty and full, with bursty requests and a stalling
// response side. Every response is checked field by field, pinned table rows
// against their table values and the rest against a running word store predictor.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_array_top;

   import iira_pkg::*;

   localparam int CAPACITY = CAPACITY_DF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_REQUESTS = 700;
   localparam int PLAN_ROWS = 26;
   localparam int HOLD_AFTER = 150;
   localparam int HOLD_CYCLES = 80;
   localparam logic [OPCODE_W-1:0] OP_NOP = 3'd7;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      status_type               status;
      logic [FILL_W-1:0]        fill;
   } response_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      logic [WORD_W-1:0]   word;
      logic [FILL_W-1:0]   reps;
      logic                fresh_word;
      logic                pinned;
      logic [WORD_W-1:0]   want_word;
      status_type          want_status;
      logic [FILL_W-1:0]   want_fill;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OPCODE_W-1:0] req_opcode = OP_APPEND;
   logic [POS_W-1:0] req_position = '0;
   logic signed [WORD_W-1:0] req_word_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_word_out;
   logic [STATUS_W-1:0] rsp_status;
   logic [FILL_W-1:0] rsp_fill_count;

   logic pin_valid = 1'b0;
   response_type pin_response = '0;

   logic signed [WORD_W-1:0] held_words [CAPACITY];
   logic [FILL_W-1:0] held_count = '0;
   logic [FILL_W-1:0] fill_hint = '0;
   response_type expected_responses [$];
   int mismatches = 0;
   int requests_taken = 0;
   int cycle_count = 0;
   int burst_left = 0;

   logic [OPCODE_W-1:0] op_order [8] = '{OP_APPEND, OP_POP, OP_INSERT, OP_REMOVE,
                                         OP_READ, OP_WRITE, OP_CLEAR, OP_NOP};
   int op_cut [3][8] = '{'{45, 50, 75, 80, 88, 98, 99, 100},
                         '{10, 35, 45, 70, 82, 96, 99, 100},
                         '{20, 35, 50, 65, 80, 95, 98, 100}};

   plan_row_type store_plan [PLAN_ROWS] = '{
      '{OP_POP,    6'd0,  32'h0000_0000, 7'd1,  1'b0, 1'b1, 32'h0, ST_RANGE, 7'd0},
      '{OP_READ,   6'd0,  32'h0000_0000, 7'd1,  1'b0, 1'b1, 32'h0, ST_RANGE, 7'd0},
      '{OP_REMOVE, 6'd63, 32'h0000_0000, 7'd1,  1'b0, 1'b1, 32'h0, ST_RANGE, 7'd0},
      '{OP_INSERT, 6'd0,  32'h1234_5678, 7'd1,  1'b0, 1'b1, 32'h0, ST_RANGE, 7'd0},
      '{OP_WRITE,  6'd0,  32'hFFFF_FFFF, 7'd1,  1'b0, 1'b1, 32'h0, ST_RANGE, 7'd0},
      '{OP_APPEND, 6'd0,  32'h7FFF_FFFF, 7'd1,  1'b0, 1'b1, 32'h0, ST_OK,    7'd1},
      '{OP_APPEND, 6'd63, 32'h8000_0000, 7'd1,  1'b0, 1'b1, 32'h0, ST_OK,    7'd2},
      '{OP_APPEND, 6'd0,  32'hFFFF_FFFF, 7'd1,  1'b0, 1'b1, 32'h0, ST_OK,    7'd3},
      '{OP_INSERT, 6'd1,  32'h0000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_READ,   6'd1,  32'h0000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_WRITE,  6'd3,  32'h5A5A_5A5A, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_REMOVE, 6'd0,  32'hFFFF_FFFF, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_READ,   6'd2,  32'h0000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_READ,   6'd3,  32'h0000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_NOP,    6'd63, 32'hFFFF_FFFF, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_POP,    6'd0,  32'h0000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_CLEAR,  6'd0,  32'h0000_0000, 7'd1,  1'b0, 1'b1, 32'h0, ST_OK,    7'd0},
      '{OP_POP,    6'd0,  32'h0000_0000, 7'd1,  1'b0, 1'b1, 32'h0, ST_RANGE, 7'd0},
      '{OP_APPEND, 6'd0,  32'h0000_0000, 7'd63, 1'b1, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_INSERT, 6'd0,  32'h0000_0001, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_APPEND, 6'd0,  32'hFFFF_FFFF, 7'd1,  1'b0, 1'b1, 32'h0, ST_FULL,  7'd64},
      '{OP_INSERT, 6'd63, 32'h0000_0000, 7'd1,  1'b0, 1'b1, 32'h0, ST_FULL,  7'd64},
      '{OP_WRITE,  6'd63, 32'h8000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_READ,   6'd63, 32'h0000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_REMOVE, 6'd63, 32'h0000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0},
      '{OP_REMOVE, 6'd0,  32'h0000_0000, 7'd1,  1'b0, 1'b0, 32'h0, ST_OK,    7'd0}
   };

   indexed_insert_remove_array_top #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_position(req_position),
      .req_word_in(req_word_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word_out(rsp_word_out),
      .rsp_status(rsp_status),
      .rsp_fill_count(rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic update_store(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [WORD_W-1:0] word,
                               output response_type outcome);
      int i;
      logic in_range;
      outcome = '0;
      outcome.status = ST_OK;
      in_range = pos < held_count;
      case (op)
         OP_APPEND: begin
            if (held_count < CAPACITY) begin
               held_words[held_count] = word;
               held_count = held_count + 1'b1;
            end else begin
               outcome.status = ST_FULL;
            end
         end
         OP_POP: begin
            if (held_count == 0) begin
               outcome.status = ST_RANGE;
            end else begin
               outcome.word = held_words[held_count - 1];
               held_count = held_count - 1'b1;
            end
         end
         OP_INSERT: begin
            if (!in_range) begin
               outcome.status = ST_RANGE;
            end else if (held_count >= CAPACITY) begin
               outcome.status = ST_FULL;
            end else begin
               for (i = held_count; i > pos; i--) held_words[i] = held_words[i - 1];
               held_words[pos] = word;
               held_count = held_count + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!in_range) begin
               outcome.status = ST_RANGE;
            end else begin
               outcome.word = held_words[pos];
               for (i = pos; i + 1 < held_count; i++) held_words[i] = held_words[i + 1];
               held_count = held_count - 1'b1;
            end
         end
         OP_READ: begin
            if (!in_range) outcome.status = ST_RANGE;
            else outcome.word = held_words[pos];
         end
         OP_WRITE: begin
            if (!in_range) outcome.status = ST_RANGE;
            else held_words[pos] = word;
         end
         OP_CLEAR: begin
            held_count = '0;
         end
         default: begin
         end
      endcase
      outcome.fill = held_count;
   endtask

   always @(posedge clock) begin
      response_type seen;
      response_type want;
      response_type outcome;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_word_out, status_type'(rsp_status), rsp_fill_count};
            if (expected_responses.size() == 0) begin
               $error("Response with no request outstanding: word %0d, status %0d, fill %0d",
                      rsp_word_out, rsp_status, rsp_fill_count);
               mismatches = mismatches + 1;
            end else begin
               want = expected_responses.pop_front();
               if (seen.word !== want.word) begin
                  $error("rsp_word_out: expected %0d, actual %0d", want.word, seen.word);
                  mismatches = mismatches + 1;
               end
               if (seen.status !== want.status) begin
                  $error("rsp_status: expected %0d, actual %0d", want.status, seen.status);
                  mismatches = mismatches + 1;
               end
               if (seen.fill !== want.fill) begin
                  $error("rsp_fill_count: expected %0d, actual %0d", want.fill, seen.fill);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            update_store(req_opcode, req_position, req_word_in, outcome);
            if (pin_valid) expected_responses.push_back(pin_response);
            else expected_responses.push_back(outcome);
            requests_taken <= requests_taken + 1;
            fill_hint <= held_count;
         end
      end
   end

   // The response side alternates stall patterns and holds off once for a long
   // stretch so that the output register fills and the request side backs up.
   initial begin
      int stretch;
      int pattern;
      bit held_off;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && requests_taken >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stretch = $urandom_range(10, 60);
         pattern = $urandom_range(0, 3);
         repeat (stretch) begin
            case (pattern)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
   endtask

   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [WORD_W-1:0] word, input logic pinned,
                               input response_type pinned_response);
      pace_sender();
      req_valid <= 1'b1;
      req_opcode <= op;
      req_position <= pos;
      req_word_in <= word;
      pin_valid <= pinned;
      pin_response <= pinned_response;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      logic signed [WORD_W-1:0] corner [4];
      corner = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1};
      if ($urandom_range(0, 9) == 0) return corner[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   initial begin
      int k;
      int r;
      int n;
      int mode;
      int roll;
      int choice;
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0] pos;
      logic signed [WORD_W-1:0] word;
      response_type pinned_response;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < PLAN_ROWS; k++) begin
         pinned_response = '{store_plan[k].want_word, store_plan[k].want_status,
                             store_plan[k].want_fill};
         for (r = 0; r < store_plan[k].reps; r++) begin
            word = store_plan[k].fresh_word ? pick_word() : store_plan[k].word;
            send_request(store_plan[k].op, store_plan[k].pos, word, store_plan[k].pinned,
                         pinned_response);
         end
      end

      // Random requests drift between growing, shrinking and mixed phases so
      // the fill count sweeps from empty to full and back.
      mode = 0;
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 80 == 0) mode = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         choice = 0;
         while (roll >= op_cut[mode][choice]) choice++;
         op = op_order[choice];
         if (fill_hint > 0 && $urandom_range(0, 9) < 8) begin
            pos = POS_W'($urandom_range(0, fill_hint - 1));
         end else begin
            pos = POS_W'($urandom_range(0, 63));
         end
         send_request(op, pos, pick_word(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
